// ===== hdl/shsfd_pkg.sv =====
// shsfd_pkg: types and constants shared by the sync-header frame deframer
// used by shsfd_frame_core and sync_header_sum_frame_deframer_unit
// no dependencies
package shsfd_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 3;
	localparam int LEN_W  = 2;

	localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'hFF;
	localparam logic [POS_W-1:0]  HEADER_LEN = 3'd2;
	localparam logic [LEN_W-1:0]  LEN_RESET  = 2'd2;

	typedef enum logic [1:0] {
		ST_PASS  = 2'd0,
		ST_VALID = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [BYTE_W-1:0]   first_value;
		logic [BYTE_W-1:0]   second_value;
	} result_t;

endpackage

// ===== hdl/shsfd_frame_core.sv =====
// shsfd_frame_core: frame state (position, running sum, payload bytes) and
// the per-word parse step that produces one result per received byte
// depends on shsfd_pkg
module shsfd_frame_core #(
	parameter int MAX_PAYLOAD_BYTES = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [shsfd_pkg::BYTE_W-1:0] rx_byte,
	input  logic [shsfd_pkg::LEN_W-1:0]  payload_length,
	output shsfd_pkg::result_t          result
);

	localparam logic [shsfd_pkg::LEN_W-1:0] LEN_MAX = shsfd_pkg::LEN_W'(MAX_PAYLOAD_BYTES);
	localparam logic [shsfd_pkg::POS_W-1:0] POS_LIMIT =
		shsfd_pkg::HEADER_LEN + shsfd_pkg::POS_W'(MAX_PAYLOAD_BYTES);

	logic [shsfd_pkg::POS_W-1:0]  pos_q, pos_d;
	logic [shsfd_pkg::BYTE_W-1:0] sum_q, sum_d;
	logic [shsfd_pkg::BYTE_W-1:0] store_q [MAX_PAYLOAD_BYTES];
	logic [shsfd_pkg::BYTE_W-1:0] store_d [MAX_PAYLOAD_BYTES];
	logic [shsfd_pkg::LEN_W-1:0]  eff_len;
	logic [shsfd_pkg::POS_W-1:0]  check_pos;

	// length 0 behaves as 1, anything above the maximum as the maximum
	always_comb begin
		if (payload_length == '0) begin
			eff_len = shsfd_pkg::LEN_W'(1);
		end else if (payload_length > LEN_MAX) begin
			eff_len = LEN_MAX;
		end else begin
			eff_len = payload_length;
		end
		check_pos = shsfd_pkg::HEADER_LEN + {1'b0, eff_len};
	end

	always_comb begin
		pos_d   = pos_q;
		sum_d   = sum_q;
		store_d = store_q;
		result  = '{status: shsfd_pkg::ST_PASS, first_value: '0, second_value: '0};
		if (pos_q < shsfd_pkg::HEADER_LEN) begin
			if (rx_byte != shsfd_pkg::SYNC_BYTE) begin
				// bad header byte: drop it and restart the frame
				pos_d = '0;
				sum_d = '0;
				for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
					store_d[i] = '0;
				end
			end else begin
				sum_d = sum_q + rx_byte;
				pos_d = pos_q + shsfd_pkg::POS_W'(1);
			end
		end else if (pos_q < check_pos) begin
			for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
				if (pos_q == shsfd_pkg::HEADER_LEN + shsfd_pkg::POS_W'(i)) begin
					store_d[i] = rx_byte;
				end
			end
			sum_d = sum_q + rx_byte;
			pos_d = pos_q + shsfd_pkg::POS_W'(1);
		end else begin
			// checksum word, also taken here if the length shrank mid-frame
			if (sum_q == rx_byte) begin
				result.status      = shsfd_pkg::ST_VALID;
				result.first_value = store_q[0];
				for (int i = 1; i < MAX_PAYLOAD_BYTES; i++) begin
					if (eff_len == shsfd_pkg::LEN_W'(2)) begin
						result.second_value = store_q[i];
					end
				end
			end else begin
				result.status = shsfd_pkg::ST_ERROR;
			end
			pos_d = '0;
			sum_d = '0;
			for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
				store_d[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
				store_q[i] <= '0;
			end
		end else if (step) begin
			pos_q   <= pos_d;
			sum_q   <= sum_d;
			store_q <= store_d;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LIMIT)
		else $error("frame position beyond checksum slot");

	a_sum_after_one_sync: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == shsfd_pkg::POS_W'(1) |-> sum_q == 8'hFF)
		else $error("running sum wrong after first header word");

	a_sum_after_two_sync: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == shsfd_pkg::HEADER_LEN |-> sum_q == 8'hFE)
		else $error("running sum wrong after header");

endmodule

// ===== hdl/sync_header_sum_frame_deframer_unit.sv =====
// path: an accepted word waits in the input register, is parsed, then lands in the result register
// throughput: one word per cycle while out_stall is low; input register, parse step and
// result register form a two-stage pipeline and the result register frees its slot when taken
// reset: arst_n clears frame position, running sum, payload bytes and both valid flags,
// and sets the payload length register to 2
// depends on shsfd_pkg and shsfd_frame_core
module sync_header_sum_frame_deframer_unit #(
	parameter int MAX_PAYLOAD_BYTES = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [shsfd_pkg::LEN_W-1:0]   cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [shsfd_pkg::BYTE_W-1:0]  rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [shsfd_pkg::BYTE_W-1:0]  first_value,
	output logic [shsfd_pkg::BYTE_W-1:0]  second_value
);

	logic [shsfd_pkg::LEN_W-1:0]   payload_length_q;
	logic                          valid_s1;
	logic [shsfd_pkg::BYTE_W-1:0]  rx_byte_s1;
	logic                          out_valid_q;
	shsfd_pkg::result_t            result_q;
	shsfd_pkg::result_t            core_result;
	logic                          advance;
	logic                          load_s1;

	assign advance  = !out_valid_q || !out_stall;
	// input register takes a word when empty or when its word moves on
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_length_q <= shsfd_pkg::LEN_RESET;
		end else if (cfg_write_en) begin
			payload_length_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
		if (advance && valid_s1) begin
			result_q <= core_result;
		end
	end

	shsfd_frame_core #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (valid_s1 && advance),
		.rx_byte        (rx_byte_s1),
		.payload_length (payload_length_q),
		.result         (core_result)
	);

	assign out_valid    = out_valid_q;
	assign status       = result_q.status;
	assign first_value  = result_q.first_value;
	assign second_value = result_q.second_value;

	a_values_zero_unless_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status != shsfd_pkg::ST_VALID
			|-> result_q.first_value == '0 && result_q.second_value == '0)
		else $error("payload values set on a non-valid status");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with a free pipeline");

	a_word_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid_q)
		else $error("parsed word lost before result register");

	a_len_two_only_if_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.second_value != '0 |-> MAX_PAYLOAD_BYTES > 1)
		else $error("second value with single payload byte build");

endmodule
